>>> rtl/circular_deque_macros.svh
// circular_deque_macros.svh: assertion macros for the deque checks
// depends on signals clk and rst_n in the module that uses them
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cdq_pkg.sv
// cdq_pkg: shared types, codes and sizes for the circular deque
// no dependencies; imported by every deque module
package cdq_pkg;

  // default ring depth and fixed field widths
  localparam int DEPTH_DEF   = 8;
  localparam int ACTION_W    = 3;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 4;

  // command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // action codes on the input
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DUMP       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // internal operation after classification
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP
  } cdq_op_t;

  // input transaction
  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;
  } cdq_in_t;

  // result transaction
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;
  } cdq_out_t;

  // classified command
  typedef struct packed {
    cdq_op_t                  op;
    logic signed [DATA_W-1:0] value;
  } cdq_cmd_t;

  // command with its valid flag, between front, queue and back
  typedef struct packed {
    logic     valid;
    cdq_cmd_t cmd;
  } cdq_slot_t;

endpackage

>>> rtl/cdq_front.sv
// cdq_front: accepts input transactions and classifies the action code
// depends on cdq_pkg; feeds cdq_cmd_queue
module cdq_front (
  input  logic              start,
  input  cdq_pkg::cdq_in_t  in_item,
  input  logic              q_full,
  output logic              busy,
  output cdq_pkg::cdq_slot_t enq
);
  import cdq_pkg::*;

  logic accept;

  // hold off new transactions while the command queue is full
  assign busy   = q_full;
  assign accept = start && !q_full;

  // decode the action; unused codes are dropped here with no result
  always_comb begin
    enq.valid     = 1'b0;
    enq.cmd.op    = OP_DUMP;
    enq.cmd.value = in_item.value;
    case (in_item.action)
      ACT_PUSH_FRONT: begin
        enq.valid  = accept;
        enq.cmd.op = OP_PUSH_FRONT;
      end
      ACT_PUSH_BACK: begin
        enq.valid  = accept;
        enq.cmd.op = OP_PUSH_BACK;
      end
      ACT_POP_FRONT: begin
        enq.valid  = accept;
        enq.cmd.op = OP_POP_FRONT;
      end
      ACT_POP_BACK: begin
        enq.valid  = accept;
        enq.cmd.op = OP_POP_BACK;
      end
      ACT_DUMP: begin
        enq.valid  = accept;
        enq.cmd.op = OP_DUMP;
      end
      default: begin
        enq.valid  = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/cdq_cmd_queue.sv
// cdq_cmd_queue: short command queue between front and back
// depends on cdq_pkg
module cdq_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  cdq_pkg::cdq_slot_t enq,
  input  logic               deq,
  output logic               full,
  output cdq_pkg::cdq_slot_t head
);
  import cdq_pkg::*;

  cdq_cmd_t           entry_r [QUEUE_DEPTH];
  logic [QP_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]    count_r, count_nxt;
  logic               do_enq, do_deq;

  assign full       = (count_r == QC_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = entry_r[rd_ptr_r];

  assign do_enq = enq.valid && !full;
  assign do_deq = deq && head.valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_enq && !do_deq) begin
      count_nxt = count_r + 1'b1;
    end else if (do_deq && !do_enq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_enq) begin
      entry_r[wr_ptr_r] <= enq.cmd;
    end
  end

endmodule

>>> rtl/cdq_back.sv
// cdq_back: executes deque commands against the ring memory
// depends on cdq_pkg; takes commands from cdq_cmd_queue
module cdq_back #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cdq_pkg::cdq_slot_t head,
  output logic               deq,
  output logic               out_valid,
  output cdq_pkg::cdq_out_t  out_item,
  output logic [CW-1:0]      fill
);
  import cdq_pkg::*;

  localparam int            IW       = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;
  cdq_out_t                 out_item_r, out_item_nxt;
  logic [IW-1:0]            front_r, front_nxt;
  logic [IW-1:0]            back_r, back_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            left_r, left_nxt;
  logic [IW-1:0]            dump_idx_r, dump_idx_nxt;

  logic signed [DATA_W-1:0] ring_mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     mem_we, mem_re;
  logic [IW-1:0]            mem_waddr, mem_raddr;

  function automatic logic [IW-1:0] idx_up(input logic [IW-1:0] i);
    idx_up = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_down(input logic [IW-1:0] i);
    idx_down = (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign fill      = fill_r;

  // command execution
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    fill_nxt      = fill_r;
    left_nxt      = left_r;
    dump_idx_nxt  = dump_idx_r;
    deq           = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = front_r;
    mem_re        = 1'b0;
    mem_raddr     = front_r;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          deq = 1'b1;
          case (head.cmd.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (fill_r == FULL_CNT) begin
                out_item_nxt = '{ST_FULL, '0, 1'b1, OCC_W'(fill_r)};
              end else begin
                mem_we = 1'b1;
                if (head.cmd.op == OP_PUSH_FRONT) begin
                  front_nxt = idx_down(front_r);
                  mem_waddr = front_nxt;
                end else begin
                  back_nxt  = idx_up(back_r);
                  mem_waddr = back_nxt;
                end
                fill_nxt     = fill_r + 1'b1;
                out_item_nxt = '{ST_OK, '0, 1'b1, OCC_W'(fill_nxt)};
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{ST_EMPTY, '0, 1'b1, '0};
              end else begin
                mem_re = 1'b1;
                if (head.cmd.op == OP_POP_FRONT) begin
                  mem_raddr = front_r;
                  front_nxt = idx_up(front_r);
                end else begin
                  mem_raddr = back_r;
                  back_nxt  = idx_down(back_r);
                end
                fill_nxt  = fill_r - 1'b1;
                left_nxt  = CW'(1);
                state_nxt = S_EMIT;
              end
            end
            OP_DUMP: begin
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{ST_EMPTY, '0, 1'b1, '0};
              end else begin
                mem_re       = 1'b1;
                mem_raddr    = front_r;
                dump_idx_nxt = idx_up(front_r);
                left_nxt     = fill_r;
                state_nxt    = S_EMIT;
              end
            end
            default: begin
              deq = 1'b1;
            end
          endcase
        end
      end
      S_EMIT: begin
        // present the word read last cycle, fetch the next one of a dump
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{ST_OK, rd_data_r, (left_r == CW'(1)), OCC_W'(fill_r)};
        if (left_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          mem_re       = 1'b1;
          mem_raddr    = dump_idx_r;
          dump_idx_nxt = idx_up(dump_idx_r);
          left_nxt     = left_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, pointers and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      front_r     <= '0;
      back_r      <= LAST_IDX;
      fill_r      <= '0;
      left_r      <= '0;
      dump_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      fill_r      <= fill_nxt;
      left_r      <= left_nxt;
      dump_idx_r  <= dump_idx_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  // ring memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= head.cmd.value;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[mem_raddr];
    end
  end

endmodule

>>> rtl/circular_deque.sv
// circular_deque: top level of the double-ended queue of 32-bit words
// depends on cdq_pkg, cdq_front, cdq_cmd_queue, cdq_back, circular_deque_macros.svh
//
// A transaction is taken when start is high and busy is low; busy rises only
// while the two-entry command queue in front of the execution unit is full.
// Results come out with a one-cycle out_valid strobe and cannot be held off.
// A push, a refused push and a refused pop or dump pass through the command
// queue and the result register; the execution unit takes one such command a
// cycle while no pop or dump holds it. A pop reads the ring memory through its
// registered read port, so its result also passes the read register, and it
// holds the unit in S_EMIT. A dump streams one word a cycle from front to back
// and holds the unit in S_EMIT until its last word. Action codes five to seven
// are dropped with no result. The ring memory needs no clearing pass after
// reset; the deque is ready at once.
`include "circular_deque_macros.svh"

module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cdq_pkg::cdq_in_t  in_item,
  output logic              out_valid,
  output cdq_pkg::cdq_out_t out_item
);
  import cdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cdq_slot_t     enq;
  cdq_slot_t     head;
  logic          q_full;
  logic          deq;
  logic [CW-1:0] fill;

  // accept and classify
  cdq_front u_front (
    .start   (start),
    .in_item (in_item),
    .q_full  (q_full),
    .busy    (busy),
    .enq     (enq)
  );

  // decoupling queue
  cdq_cmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .enq   (enq),
    .deq   (deq),
    .full  (q_full),
    .head  (head)
  );

  // execution against the ring memory
  cdq_back #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .deq       (deq),
    .out_valid (out_valid),
    .out_item  (out_item),
    .fill      (fill)
  );

  // checks
  `CDQ_ASSERT_IMP(a_refusal_shape, out_valid && (out_item.status != ST_OK), (out_item.data == '0) && out_item.last, "refused transaction must carry zero data and last")
  `CDQ_ASSERT_IMP(a_full_only_when_full, out_valid && (out_item.status == ST_FULL), fill == CW'(DEPTH), "full status while deque not full")
  `CDQ_ASSERT_IMP(a_empty_only_when_empty, out_valid && (out_item.status == ST_EMPTY), fill == '0, "empty status while deque holds words")
  `CDQ_ASSERT_NXT(a_dump_contiguous, out_valid && !out_item.last, out_valid && (out_item.status == ST_OK), "dump stream broken before last word")

endmodule

>>> bench/tb_circular_deque.sv
// tb_circular_deque: self-checking bench for the circular deque
// depends on cdq_pkg and the circular_deque rtl; a deque tracker predicts
// every result, which is checked field by field as it leaves the block
module tb_circular_deque;
  import cdq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  // action codes the block drops without a result
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  localparam int MAX_REPORTS = 10;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  cdq_in_t  in_item;
  logic     out_valid;
  cdq_out_t out_item;

  // tracked deque contents and the results still to come out
  logic signed [DATA_W-1:0] ring_copy [DEPTH];
  int unsigned              head_idx = 0;
  int unsigned              tail_idx = DEPTH - 1;
  int unsigned              stored   = 0;
  cdq_out_t                 awaited_results [$];
  int                       fail_count = 0;

  circular_deque #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // track accepted transactions, then check any result leaving the block
  always @(posedge clk) begin : scoreboard
    cdq_out_t res;
    cdq_out_t got;
    int unsigned idx;

    if (rst_n && start && !busy) begin
      res = '0;
      res.last = 1'b1;
      case (in_item.action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (stored >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            if (in_item.action == ACT_PUSH_FRONT) begin
              head_idx = (head_idx + DEPTH - 1) % DEPTH;
              ring_copy[head_idx] = in_item.value;
            end else begin
              tail_idx = (tail_idx + 1) % DEPTH;
              ring_copy[tail_idx] = in_item.value;
            end
            stored++;
            res.status = ST_OK;
          end
          res.occupancy = OCC_W'(stored);
          awaited_results.push_back(res);
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (stored == 0) begin
            res.status = ST_EMPTY;
          end else begin
            if (in_item.action == ACT_POP_FRONT) begin
              res.data = ring_copy[head_idx];
              head_idx = (head_idx + 1) % DEPTH;
            end else begin
              res.data = ring_copy[tail_idx];
              tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
            end
            stored--;
            res.status = ST_OK;
          end
          res.occupancy = OCC_W'(stored);
          awaited_results.push_back(res);
        end
        ACT_DUMP: begin
          if (stored == 0) begin
            res.status = ST_EMPTY;
            awaited_results.push_back(res);
          end else begin
            // one result per stored word, front to back
            idx = head_idx;
            for (int i = 0; i < stored; i++) begin
              res.status    = ST_OK;
              res.data      = ring_copy[idx];
              res.last      = (i + 1 == stored);
              res.occupancy = OCC_W'(stored);
              awaited_results.push_back(res);
              idx = (idx + 1) % DEPTH;
            end
          end
        end
        default: begin
          // spare codes: dropped, no result
        end
      endcase
    end

    if (rst_n && out_valid) begin
      got = out_item;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: status %0d data %0d last %0d occ %0d",
                   got.status, got.data, got.last, got.occupancy);
      end else begin
        res = awaited_results.pop_front();
        if (got.status !== res.status || got.data !== res.data ||
            got.last !== res.last || got.occupancy !== res.occupancy) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("result mismatch: expected status %0d data %0d last %0d occ %0d",
                     res.status, res.data, res.last, res.occupancy);
            $display("                 got status %0d data %0d last %0d occ %0d",
                     got.status, got.data, got.last, got.occupancy);
          end
        end
      end
    end
  end

  function automatic cdq_in_t make_txn(input logic [ACTION_W-1:0] act,
                                       input logic [DATA_W-1:0] val);
    cdq_in_t t;
    t.action = act;
    t.value  = val;
    return t;
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic send_action(input cdq_in_t txn);
    start   <= 1'b1;
    in_item <= txn;
    do @(posedge clk); while (busy);
  endtask

  // sender gap with noise on the payload
  task automatic idle_cycles(input int n);
    start   <= 1'b0;
    in_item <= make_txn(ACTION_W'($urandom), $urandom);
    repeat (n) @(posedge clk);
  endtask

  // word with the extremes mixed in
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // action mix with a given share of pushes among pushes and pops
  function automatic logic [ACTION_W-1:0] pick_action(input int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3)
      return ACTION_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
    if (r < 10)
      return ACT_DUMP;
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  // pops and dump on the empty deque
  task automatic test_empty_refusals();
    send_action(make_txn(ACT_POP_FRONT, 32'h1234_5678));
    send_action(make_txn(ACT_POP_BACK, 32'hFFFF_FFFF));
    send_action(make_txn(ACT_DUMP, 32'h0000_0000));
  endtask

  // fill from both ends with extreme words, refuse, list, pop both ends
  task automatic test_fill_both_ends();
    send_action(make_txn(ACT_PUSH_FRONT, 32'h8000_0000));
    send_action(make_txn(ACT_PUSH_BACK, 32'h7FFF_FFFF));
    send_action(make_txn(ACT_PUSH_FRONT, 32'hFFFF_FFFF));
    send_action(make_txn(ACT_PUSH_BACK, 32'h0000_0000));
    send_action(make_txn(ACT_PUSH_FRONT, 32'h5555_5555));
    send_action(make_txn(ACT_PUSH_BACK, 32'hAAAA_AAAA));
    send_action(make_txn(ACT_PUSH_FRONT, 32'h0000_0001));
    send_action(make_txn(ACT_PUSH_BACK, 32'h8000_0001));
    // full deque
    send_action(make_txn(ACT_PUSH_FRONT, 32'hDEAD_BEEF));
    send_action(make_txn(ACT_PUSH_BACK, 32'hCAFE_F00D));
    send_action(make_txn(ACT_DUMP, 32'h0000_0000));
    send_action(make_txn(ACT_POP_FRONT, 32'h0000_0000));
    send_action(make_txn(ACT_POP_BACK, 32'h0000_0000));
  endtask

  // spare codes give no result
  task automatic test_spare_codes();
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      send_action(make_txn(ACTION_W'(a), $urandom));
    send_action(make_txn(ACT_DUMP, 32'h0000_0000));
  endtask

  // phases that lean towards filling, draining or neither, sent in bursts
  task automatic test_random_traffic(input int n_items);
    int counted;
    int burst_left;
    int push_pct;
    int phase_left;
    logic [ACTION_W-1:0] act;

    counted    = 0;
    burst_left = 0;
    phase_left = 0;
    push_pct   = 50;
    while (counted < n_items) begin
      if (phase_left == 0) begin
        case ($urandom_range(3))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = $urandom_range(70, 30);
        endcase
        phase_left = $urandom_range(60, 20);
      end
      if (burst_left == 0) begin
        idle_cycles($urandom_range(8, 1));
        burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 30)
                                               : $urandom_range(12, 1);
      end
      act = pick_action(push_pct);
      send_action(make_txn(act, pick_value()));
      if (act <= ACT_DUMP) begin
        counted++;
        phase_left--;
      end
      burst_left--;
    end
  endtask

  // stimulus and end of run
  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_refusals();
    test_fill_both_ends();
    test_spare_codes();
    idle_cycles(3);
    test_random_traffic(450);
    idle_cycles(1);

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    fail_count += awaited_results.size();

    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
